// File: sv/gskg_pkg.sv
package gskg_pkg;

	// Fixed field widths.
	localparam int KEY_W   = 16;
	localparam int GATE_W  = 24;
	localparam int BETA_W  = 16;
	localparam int ROW_W   = 6;
	localparam int ENTRY_W = 32;
	localparam int DOT_W   = 40;
	localparam int PROD_W  = 32;
	localparam int FACT_W  = 24;

	// Parameter defaults.
	localparam int MAX_ROWS_DEF     = 64;
	localparam int MAX_FEATURES_DEF = 128;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_GATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FEATURES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 2'd2;
	localparam logic [7:0] FEATURES_RESET = 8'd128;
	localparam logic [6:0] ROWS_RESET     = 7'd64;

	// Serial multiplier operand widths.
	localparam int MUL_A_W = 48;
	localparam int MUL_B_W = 32;

	// Fixed-point constants.
	localparam logic [31:0] LOG2E_Q16  = 32'd94548;
	localparam logic [47:0] LN2_Q30    = 48'd744261118;
	localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
	localparam logic [FACT_W-1:0] ONE_Q16    = 24'h01_0000;
	localparam logic [FACT_W-1:0] FACTOR_MAX = 24'hFF_FFFF;

	typedef struct packed {
		logic signed [KEY_W-1:0]  key_elem;
		logic signed [GATE_W-1:0] gate;
		logic [BETA_W-1:0]        beta_weight;
		logic                     last_of_chunk;
	} key_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]          row_index;
		logic [ROW_W-1:0]          col_index;
		logic signed [ENTRY_W-1:0] entry_value;
		logic                      row_done;
	} gram_item_t;

	typedef struct packed {
		logic                    wr_en;
		logic                    gate_wr;
		logic                    mac_en;
		logic                    clear;
		logic                    load;
		logic                    shift;
		logic signed [KEY_W-1:0] wkey;
		logic signed [KEY_W-1:0] mkey;
	} cell_ctl_t;

endpackage

// File: sv/gskg_ram.sv
module gskg_ram #(
	parameter int W = 16,
	parameter int D = 128
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                  wdata,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/gskg_cell.sv
module gskg_cell #(
	parameter int MAX_ROWS     = gskg_pkg::MAX_ROWS_DEF,
	parameter int MAX_FEATURES = gskg_pkg::MAX_FEATURES_DEF,
	parameter int IDX          = 0,
	localparam int RW = $clog2(MAX_ROWS),
	localparam int EW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gskg_pkg::cell_ctl_t                 ctl,
	input  logic [RW-1:0]                       row,
	input  logic [EW-1:0]                       addr,
	input  logic signed [gskg_pkg::GATE_W-1:0]  gate_in,
	input  logic signed [gskg_pkg::DOT_W-1:0]   nxt_acc,
	input  logic signed [gskg_pkg::GATE_W-1:0]  nxt_gate,
	output logic signed [gskg_pkg::DOT_W-1:0]   sh_acc,
	output logic signed [gskg_pkg::GATE_W-1:0]  sh_gate
);

	logic                                sel;
	logic                                active;
	logic [gskg_pkg::KEY_W-1:0]          rdata;
	logic signed [gskg_pkg::PROD_W-1:0]  prod;
	logic signed [gskg_pkg::DOT_W-1:0]   base;
	logic signed [gskg_pkg::DOT_W-1:0]   acc_q;
	logic signed [gskg_pkg::GATE_W-1:0]  gate_q;
	logic signed [gskg_pkg::DOT_W-1:0]   sh_acc_q;
	logic signed [gskg_pkg::GATE_W-1:0]  sh_gate_q;

	assign sel    = (row == RW'(IDX));
	assign active = (RW'(IDX) < row);

	gskg_ram #(
		.W(gskg_pkg::KEY_W),
		.D(MAX_FEATURES)
	) u_keys (
		.clk  (clk),
		.we   (ctl.wr_en && sel),
		.waddr(addr),
		.wdata(ctl.wkey),
		.raddr(addr),
		.rdata(rdata)
	);

	assign prod = ctl.mkey * $signed(rdata);
	assign base = ctl.clear ? '0 : acc_q;

	// Accumulator is cleared on a row's first element; only earlier rows add.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.mac_en) begin
			acc_q <= active ? base + gskg_pkg::DOT_W'(prod) : base;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.gate_wr && sel) begin
			gate_q <= gate_in;
		end
		if (ctl.load) begin
			sh_acc_q  <= acc_q;
			sh_gate_q <= gate_q;
		end else if (ctl.shift) begin
			sh_acc_q  <= nxt_acc;
			sh_gate_q <= nxt_gate;
		end
	end

	assign sh_acc  = sh_acc_q;
	assign sh_gate = sh_gate_q;

endmodule

// File: sv/gskg_smul.sv
module gskg_smul #(
	parameter int A_W = gskg_pkg::MUL_A_W,
	parameter int B_W = gskg_pkg::MUL_B_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               done,
	output logic [A_W+B_W-1:0] p
);

	localparam int CW = $clog2(B_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CW-1:0]      cnt_q;
	logic [A_W-1:0]     a_q;
	logic [A_W+B_W-1:0] p_q;
	logic [A_W:0]       sum;

	// One multiplier bit per cycle, least significant first.
	assign sum = {1'b0, p_q[A_W+B_W-1:B_W]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= a;
			p_q <= {{A_W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[B_W-1:1]};
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

// File: sv/gskg_post.sv
module gskg_post (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                use_gate,
	input  logic signed [gskg_pkg::DOT_W-1:0]   dot,
	input  logic signed [gskg_pkg::GATE_W-1:0]  gate_i,
	input  logic signed [gskg_pkg::GATE_W-1:0]  gate_j,
	input  logic [gskg_pkg::BETA_W-1:0]         beta,
	output logic                                done,
	output logic signed [gskg_pkg::ENTRY_W-1:0] value
);

	localparam int AW = gskg_pkg::MUL_A_W;
	localparam int BW = gskg_pkg::MUL_B_W;

	localparam logic [3:0] P_IDLE = 4'd0;
	localparam logic [3:0] P_LOG  = 4'd1;
	localparam logic [3:0] P_Z    = 4'd2;
	localparam logic [3:0] P_HGO  = 4'd3;
	localparam logic [3:0] P_HMUL = 4'd4;
	localparam logic [3:0] P_HDIV = 4'd5;
	localparam logic [3:0] P_MANT = 4'd6;
	localparam logic [3:0] P_M1GO = 4'd7;
	localparam logic [3:0] P_M1   = 4'd8;
	localparam logic [3:0] P_M2   = 4'd9;

	localparam logic signed [27:0] L_HI   = 28'sd524288;
	localparam logic signed [27:0] L_LO   = -28'sd1572864;
	localparam logic signed [27:0] L_BIAS = 28'sd1572864;

	// Reciprocals ceil(2^45 / k); the quotient is bits 76:45 of the product.
	localparam logic [AW-1:0] REC_1 = 48'd35184372088832;
	localparam logic [AW-1:0] REC_2 = 48'd17592186044416;
	localparam logic [AW-1:0] REC_3 = 48'd11728124029611;
	localparam logic [AW-1:0] REC_4 = 48'd8796093022208;
	localparam logic [AW-1:0] REC_5 = 48'd7036874417767;
	localparam logic [AW-1:0] REC_6 = 48'd5864062014806;
	localparam logic [AW-1:0] REC_7 = 48'd5026338869834;

	logic [3:0]                         st_q;
	logic                               go_q;
	logic [AW-1:0]                      ma_q;
	logic [BW-1:0]                      mb_q;
	logic                               mul_done;
	logic [AW+BW-1:0]                   mul_p;
	logic                               neg_q;
	logic                               lneg_q;
	logic [gskg_pkg::DOT_W-1:0]         dmag_q;
	logic [gskg_pkg::BETA_W-1:0]        beta_q;
	logic [gskg_pkg::FACT_W-1:0]        f_q;
	logic [4:0]                         nb_q;
	logic [29:0]                        z_q;
	logic [31:0]                        r_q;
	logic [2:0]                         k_q;
	logic                               done_q;
	logic signed [gskg_pkg::ENTRY_W-1:0] val_q;

	logic signed [24:0]                 gd;
	logic [24:0]                        gmag;
	logic [gskg_pkg::DOT_W-1:0]         dmag;
	logic [41:0]                        lsum;
	logic signed [27:0]                 lval;
	logic [27:0]                        biased;
	logic [AW-1:0]                      recip;
	logic [32:0]                        msum;
	logic [25:0]                        mant;
	logic [25:0]                        vfac;
	logic [63:0]                        asum;
	logic [63:0]                        esum;
	logic [41:0]                        emag;
	logic signed [gskg_pkg::ENTRY_W-1:0] sat;

	gskg_smul #(
		.A_W(AW),
		.B_W(BW)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (go_q),
		.a     (ma_q),
		.b     (mb_q),
		.done  (mul_done),
		.p     (mul_p)
	);

	always_comb begin
		gd     = 25'(gate_i) - 25'(gate_j);
		gmag   = gd[24] ? 25'(-gd) : 25'(gd);
		dmag   = dot[gskg_pkg::DOT_W-1] ? gskg_pkg::DOT_W'(-dot) : gskg_pkg::DOT_W'(dot);
		lsum   = mul_p[41:0] + 42'd32768;
		lval   = lneg_q ? -$signed({2'b00, lsum[41:16]}) : $signed({2'b00, lsum[41:16]});
		biased = 28'(lval + L_BIAS);
		case (k_q)
			3'd2: recip = REC_2;
			3'd3: recip = REC_3;
			3'd4: recip = REC_4;
			3'd5: recip = REC_5;
			3'd6: recip = REC_6;
			3'd7: recip = REC_7;
			default: recip = REC_1;
		endcase
		msum   = {1'b0, r_q} + 33'd8192;
		mant   = 26'(msum[32:14]);
		if (nb_q >= 5'd24) begin
			vfac = mant << (nb_q - 5'd24);
		end else begin
			vfac = (mant + (26'd1 << (5'd23 - nb_q))) >> (5'd24 - nb_q);
		end
		asum = mul_p[63:0] + 64'd32768;
		esum = mul_p[63:0] + 64'h20_0000;
		emag = esum[63:22];
		if (!neg_q) begin
			sat = (emag > 42'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(emag[31:0]);
		end else begin
			sat = (emag >= 42'h0_8000_0000) ? 32'sh8000_0000 : -$signed(emag[31:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= P_IDLE;
			go_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			case (st_q)
				P_IDLE: begin
					if (start) begin
						if (use_gate) begin
							go_q <= 1'b1;
							st_q <= P_LOG;
						end else begin
							st_q <= P_M1GO;
						end
					end
				end
				P_LOG: begin
					if (mul_done) begin
						if (lval >= L_HI || lval < L_LO) begin
							st_q <= P_M1GO;
						end else begin
							go_q <= 1'b1;
							st_q <= P_Z;
						end
					end
				end
				P_Z: begin
					if (mul_done) begin
						st_q <= P_HGO;
					end
				end
				P_HGO: begin
					go_q <= 1'b1;
					st_q <= P_HMUL;
				end
				P_HMUL: begin
					if (mul_done) begin
						go_q <= 1'b1;
						st_q <= P_HDIV;
					end
				end
				P_HDIV: begin
					if (mul_done) begin
						st_q <= (k_q == 3'd1) ? P_MANT : P_HGO;
					end
				end
				P_MANT: begin
					st_q <= P_M1GO;
				end
				P_M1GO: begin
					go_q <= 1'b1;
					st_q <= P_M1;
				end
				P_M1: begin
					if (mul_done) begin
						go_q <= 1'b1;
						st_q <= P_M2;
					end
				end
				P_M2: begin
					if (mul_done) begin
						done_q <= 1'b1;
						st_q   <= P_IDLE;
					end
				end
				default: begin
					st_q <= P_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; the control above decides when they matter.
	always_ff @(posedge clk) begin
		case (st_q)
			P_IDLE: begin
				if (start) begin
					neg_q  <= dot[gskg_pkg::DOT_W-1];
					dmag_q <= dmag;
					beta_q <= beta;
					lneg_q <= gd[24];
					f_q    <= gskg_pkg::ONE_Q16;
					ma_q   <= AW'(gmag);
					mb_q   <= gskg_pkg::LOG2E_Q16;
				end
			end
			P_LOG: begin
				if (mul_done) begin
					if (lval >= L_HI) begin
						f_q <= gskg_pkg::FACTOR_MAX;
					end else if (lval < L_LO) begin
						f_q <= '0;
					end
					nb_q <= biased[20:16];
					ma_q <= gskg_pkg::LN2_Q30;
					mb_q <= BW'(biased[15:0]);
				end
			end
			P_Z: begin
				if (mul_done) begin
					z_q <= mul_p[45:16];
					r_q <= gskg_pkg::ONE_Q30;
					k_q <= 3'd7;
				end
			end
			P_HGO: begin
				ma_q <= AW'(r_q);
				mb_q <= BW'(z_q);
			end
			P_HMUL: begin
				// The series divide by k is a multiply by its reciprocal.
				if (mul_done) begin
					ma_q <= recip;
					mb_q <= mul_p[61:30];
				end
			end
			P_HDIV: begin
				if (mul_done) begin
					r_q <= gskg_pkg::ONE_Q30 + mul_p[76:45];
					k_q <= k_q - 1'b1;
				end
			end
			P_MANT: begin
				f_q <= (vfac > 26'(gskg_pkg::FACTOR_MAX)) ? gskg_pkg::FACTOR_MAX
					: vfac[gskg_pkg::FACT_W-1:0];
			end
			P_M1GO: begin
				ma_q <= AW'(dmag_q);
				mb_q <= BW'(f_q);
			end
			P_M1: begin
				if (mul_done) begin
					ma_q <= asum[63:16];
					mb_q <= BW'(beta_q);
				end
			end
			P_M2: begin
				if (mul_done) begin
					val_q <= sat;
				end
			end
			default: begin
			end
		endcase
	end

	assign done  = done_q;
	assign value = val_q;

endmodule

// File: sv/gated_scaled_key_gram.sv
// Gated, beta-scaled key Gram row generator.
//
// Key rows of one chunk arrive on the key channel one element per transaction;
// the gate and beta of a row are taken from its first element, and the
// last_of_chunk flag is looked at only on the row's last element. The block
// takes one element per cycle while a row streams in: every earlier row owns a
// cell in a chain, and each cell does one multiply-accumulate per element
// against its own key memory. After the last element the chain shifts its dot
// products out one column at a time, and rows_per_chunk transactions leave on
// the gram channel, row_done marking the last column.
// Without gating an entry below the diagonal takes two serial multiplies; with
// gating it takes eighteen multiplies on the shared serial multiplier, two for
// each step of the seven-step exp series. A saturated gate factor skips the
// series. A column at or above the diagonal needs no multiply and gives zero;
// the first result follows the row's last element through the drain, load
// and column states, and the scaling unit when the entry needs it.
// Reset clears the configuration to its defaults and puts the block at row 0,
// element 0; key memories and stored gates hold nothing defined until written.
// A stalled receiver holds the last result in the output register and the
// column sequence waits; no result is dropped.
module gated_scaled_key_gram #(
	parameter int MAX_ROWS     = gskg_pkg::MAX_ROWS_DEF,
	parameter int MAX_FEATURES = gskg_pkg::MAX_FEATURES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               key_valid,
	output logic                               key_ready,
	input  gskg_pkg::key_item_t                key_item,
	output logic                               gram_valid,
	input  logic                               gram_ready,
	output gskg_pkg::gram_item_t               gram_item,
	input  logic                               cfg_write_en,
	input  logic [gskg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gskg_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int RW  = $clog2(MAX_ROWS);
	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int EW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int FCW = $clog2(MAX_FEATURES + 1);

	localparam logic [2:0] S_RUN   = 3'd0;
	localparam logic [2:0] S_DRAIN = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_COL   = 3'd3;
	localparam logic [2:0] S_WAIT  = 3'd4;
	localparam logic [2:0] S_PUT   = 3'd5;

	// Configuration registers.
	logic       use_gate_q;
	logic [7:0] fc_q;
	logic [6:0] rpc_q;

	// Control state.
	logic [2:0]     st_q;
	logic [FCW-1:0] ec_q;
	logic [RW-1:0]  row_q;
	logic [RW-1:0]  col_q;
	logic           last_q;
	logic           out_valid_q;
	logic           mac_s1;
	logic           first_s1;
	logic [gskg_pkg::BETA_W-1:0]          beta_q;

	// Payload registers.
	logic signed [gskg_pkg::KEY_W-1:0]    key_s1;
	logic signed [gskg_pkg::GATE_W-1:0]   row_gate_q;
	logic signed [gskg_pkg::ENTRY_W-1:0]  res_q;
	gskg_pkg::gram_item_t                 out_q;

	logic [8:0]     fc9;
	logic [FCW-1:0] fc_eff;
	logic [RCW-1:0] rpc_eff;
	logic [FCW-1:0] e_cnt;
	logic           e_last;
	logic           first;
	logic           accept;
	logic           put_fire;
	logic           col_last;
	logic           row_wrap;
	logic           post_start;
	logic           post_done;
	logic signed [gskg_pkg::ENTRY_W-1:0]  post_value;
	gskg_pkg::cell_ctl_t                  ctl;

	logic signed [gskg_pkg::DOT_W-1:0]  sh_acc_w  [MAX_ROWS+1];
	logic signed [gskg_pkg::GATE_W-1:0] sh_gate_w [MAX_ROWS+1];

	// Effective sizes: both registers are clamped into their legal ranges.
	always_comb begin
		fc9 = {1'b0, fc_q};
		if (fc9 == 9'd0) begin
			fc_eff = FCW'(1);
		end else if (fc9 > 9'(MAX_FEATURES)) begin
			fc_eff = FCW'(MAX_FEATURES);
		end else begin
			fc_eff = FCW'(fc9);
		end
		if (rpc_q == 7'd0) begin
			rpc_eff = RCW'(1);
		end else if (rpc_q > 7'(MAX_ROWS)) begin
			rpc_eff = RCW'(MAX_ROWS);
		end else begin
			rpc_eff = RCW'(rpc_q);
		end
	end

	// A lowered feature_count holds the element position at the new last one.
	assign e_cnt   = (ec_q >= fc_eff) ? fc_eff - 1'b1 : ec_q;
	assign e_last  = (e_cnt == fc_eff - 1'b1);
	assign first   = (ec_q == '0);

	assign key_ready = (st_q == S_RUN);
	assign accept    = key_valid && key_ready;
	assign put_fire  = (st_q == S_PUT) && (!out_valid_q || gram_ready);
	assign col_last  = (RCW'(col_q) + 1'b1 == rpc_eff);
	assign row_wrap  = (RCW'(row_q) + 1'b1 >= rpc_eff) || last_q;
	assign post_start = (st_q == S_COL) && (col_q < row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_gate_q <= 1'b0;
			fc_q       <= gskg_pkg::FEATURES_RESET;
			rpc_q      <= gskg_pkg::ROWS_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				gskg_pkg::CFG_USE_GATE: use_gate_q <= cfg_data[0];
				gskg_pkg::CFG_FEATURES: fc_q       <= cfg_data;
				gskg_pkg::CFG_ROWS:     rpc_q      <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// Row sequencer: stream elements, drain the last MAC, then walk columns.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_RUN;
			ec_q        <= '0;
			row_q       <= '0;
			col_q       <= '0;
			last_q      <= 1'b0;
			beta_q      <= '0;
			mac_s1      <= 1'b0;
			first_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mac_s1 <= accept;
			if (accept) begin
				first_s1 <= first;
				ec_q     <= e_last ? '0 : e_cnt + 1'b1;
				if (first) begin
					beta_q <= key_item.beta_weight;
				end
			end
			if (put_fire) begin
				out_valid_q <= 1'b1;
			end else if (gram_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_RUN: begin
					if (accept && e_last) begin
						last_q <= key_item.last_of_chunk;
						st_q   <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					st_q <= S_LOAD;
				end
				S_LOAD: begin
					col_q <= '0;
					st_q  <= S_COL;
				end
				S_COL: begin
					st_q <= post_start ? S_WAIT : S_PUT;
				end
				S_WAIT: begin
					if (post_done) begin
						st_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (put_fire) begin
						if (col_last) begin
							row_q <= row_wrap ? '0 : row_q + 1'b1;
							st_q  <= S_RUN;
						end else begin
							col_q <= col_q + 1'b1;
							st_q  <= S_COL;
						end
					end
				end
				default: begin
					st_q <= S_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1 <= key_item.key_elem;
			if (first) begin
				row_gate_q <= key_item.gate;
			end
		end
		if (st_q == S_COL && !post_start) begin
			res_q <= '0;
		end else if (st_q == S_WAIT && post_done) begin
			res_q <= post_value;
		end
		if (put_fire) begin
			out_q.row_index   <= gskg_pkg::ROW_W'(row_q);
			out_q.col_index   <= gskg_pkg::ROW_W'(col_q);
			out_q.entry_value <= res_q;
			out_q.row_done    <= col_last;
		end
	end

	always_comb begin
		ctl.wr_en   = accept;
		ctl.gate_wr = accept && first;
		ctl.mac_en  = mac_s1;
		ctl.clear   = first_s1;
		ctl.load    = (st_q == S_LOAD);
		ctl.shift   = put_fire;
		ctl.wkey    = key_item.key_elem;
		ctl.mkey    = key_s1;
	end

	// The chain end feeds zeros; cell 0 is the head read by the column walk.
	assign sh_acc_w[MAX_ROWS]  = '0;
	assign sh_gate_w[MAX_ROWS] = '0;

	for (genvar j = 0; j < MAX_ROWS; j++) begin : g_cell
		gskg_cell #(
			.MAX_ROWS    (MAX_ROWS),
			.MAX_FEATURES(MAX_FEATURES),
			.IDX         (j)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.row     (row_q),
			.addr    (e_cnt[EW-1:0]),
			.gate_in (key_item.gate),
			.nxt_acc (sh_acc_w[j+1]),
			.nxt_gate(sh_gate_w[j+1]),
			.sh_acc  (sh_acc_w[j]),
			.sh_gate (sh_gate_w[j])
		);
	end

	gskg_post u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (post_start),
		.use_gate(use_gate_q),
		.dot     (sh_acc_w[0]),
		.gate_i  (row_gate_q),
		.gate_j  (sh_gate_w[0]),
		.beta    (beta_q),
		.done    (post_done),
		.value   (post_value)
	);

	assign gram_valid = out_valid_q;
	assign gram_item  = out_q;

	// The scaling unit only answers while the sequencer waits for it.
	a_post_done: assert property (@(posedge clk) disable iff (!arst_n)
		post_done |-> st_q == S_WAIT)
		else $error("scaling unit finished outside the wait state");

	// A column being sent always lies inside the configured row length.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_PUT |-> RCW'(col_q) < rpc_eff)
		else $error("column index beyond row length");

	// The key channel closes right after a row's last element.
	a_row_close: assert property (@(posedge clk) disable iff (!arst_n)
		accept && e_last |=> !key_ready)
		else $error("key channel still open after row end");

	// A result handed to the output register is offered in the next cycle.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		put_fire |=> gram_valid)
		else $error("result loaded but not offered");

endmodule
